// ----- src/grn_pkg.sv -----
// shared types, constants and key mapping for the pad report normalizer
package grn_pkg;

	localparam int NUM_W     = 27;
	localparam int DEN_W     = 12;
	localparam int STICK_W   = 12;
	localparam int TRIG_W    = 8;
	localparam int LANES     = 6;
	localparam int STICKS    = 4;
	localparam int DIV_STEPS = NUM_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0]   DIV_LAST       = CNT_W'(DIV_STEPS - 1);
	localparam logic [STICK_W-1:0] STICK_LOW_SEED = 12'd1148;
	localparam logic [STICK_W-1:0] STICK_HIGH_SEED = 12'd2948;
	localparam logic [TRIG_W-1:0]  TRIG_LOW_SEED  = 8'd20;
	localparam logic [TRIG_W-1:0]  TRIG_HIGH_SEED = 8'd210;
	localparam logic [NUM_W-1:0]   POS_FULL       = NUM_W'(32767);
	localparam logic [NUM_W-1:0]   NEG_FULL       = NUM_W'(32768);
	localparam logic [NUM_W-1:0]   TRIG_FULL      = NUM_W'(1023);

	localparam logic [4:0] KEY_SRC [16] = '{
		5'd19, 5'd18, 5'd17, 5'd16, 5'd7, 5'd23, 5'd6, 5'd22,
		5'd13, 5'd9, 5'd14, 5'd12, 5'd1, 5'd0, 5'd3, 5'd2
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} grn_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} lane_ctrl_t;

endpackage

// ----- src/gamepad_report_autorange_normalizer.sv -----
// top level: key masks, range tracking, six divider lanes and output register
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | button_word, four sticks, two triggers
//  out     | out_valid / out_stall| key masks, four scaled sticks, gas, brake
//
// one request goes from accept to result through 27 divider steps in six
// lanes running side by side, then the done state loads the output register
// once it is free; a new request is taken only after that load, even if the
// new result still waits on out_stall
// arst_n clears control, learned ranges to their seeds and the key history
module gamepad_report_autorange_normalizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [23:0]        button_word,
	input  logic [11:0]        left_stick_x,
	input  logic [11:0]        left_stick_y,
	input  logic [11:0]        right_stick_x,
	input  logic [11:0]        right_stick_y,
	input  logic [7:0]         left_trigger,
	input  logic [7:0]         right_trigger,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        key_state,
	output logic [15:0]        key_changed,
	output logic signed [15:0] left_x_scaled,
	output logic signed [15:0] left_y_scaled,
	output logic signed [15:0] right_x_scaled,
	output logic signed [15:0] right_y_scaled,
	output logic [9:0]         gas_level,
	output logic [9:0]         brake_level
);

	grn_pkg::grn_state_t state_q, state_n;
	logic [grn_pkg::CNT_W-1:0] cnt_q;
	logic acc, load_out;
	grn_pkg::lane_ctrl_t ctrl;

	logic [grn_pkg::STICK_W-1:0] raw [grn_pkg::STICKS];
	logic [grn_pkg::STICK_W-1:0] lo_q [grn_pkg::STICKS];
	logic [grn_pkg::STICK_W-1:0] hi_q [grn_pkg::STICKS];
	logic [grn_pkg::TRIG_W-1:0]  traw [2];
	logic [grn_pkg::TRIG_W-1:0]  tlo_q [2];
	logic [grn_pkg::TRIG_W-1:0]  thi_q [2];
	logic [grn_pkg::NUM_W-1:0]   num [grn_pkg::LANES];
	logic [grn_pkg::DEN_W-1:0]   den [grn_pkg::LANES];
	logic [grn_pkg::NUM_W-1:0]   quo [grn_pkg::LANES];
	logic [grn_pkg::STICKS-1:0]  neg, neg_q;
	logic [15:0] keys, prev_q, keys_q, chg_q;
	logic        first_q;
	logic signed [15:0] stick [grn_pkg::STICKS];
	logic [9:0]  trig [2];

	assign raw[0]  = left_stick_x;
	assign raw[1]  = left_stick_y;
	assign raw[2]  = right_stick_x;
	assign raw[3]  = right_stick_y;
	assign traw[0] = left_trigger;
	assign traw[1] = right_trigger;

	assign acc      = in_valid && !in_stall;
	assign in_stall = (state_q != grn_pkg::ST_IDLE);

	always_comb begin
		for (int k = 0; k < 16; k++) begin
			keys[k] = button_word[grn_pkg::KEY_SRC[k]];
		end
	end

	always_comb begin
		logic [12:0] dn;
		logic [11:0] dp;
		logic [12:0] sn;
		logic [8:0]  dt;
		for (int i = 0; i < grn_pkg::STICKS; i++) begin
			neg[i] = !raw[i][11];
			dn = 13'd2048 - {1'b0, raw[i]};
			dp = {1'b0, raw[i][10:0]};
			if (neg[i]) begin
				num[i] = {dn[11:0], 15'b0};
				sn     = 13'd2048 - {1'b0, lo_q[i]};
			end else begin
				num[i] = {dp, 15'b0} - grn_pkg::NUM_W'(dp);
				sn     = {1'b0, hi_q[i]} - 13'd2048;
			end
			den[i] = sn[11:0];
		end
		for (int t = 0; t < 2; t++) begin
			dt = {1'b0, traw[t]} - {1'b0, tlo_q[t]};
			if (traw[t] > tlo_q[t]) begin
				num[grn_pkg::STICKS+t] = grn_pkg::NUM_W'({dt[7:0], 10'b0}) -
					grn_pkg::NUM_W'(dt[7:0]);
			end else begin
				num[grn_pkg::STICKS+t] = '0;
			end
			den[grn_pkg::STICKS+t] = grn_pkg::DEN_W'(thi_q[t] - tlo_q[t]);
		end
	end

	always_comb begin
		state_n   = state_q;
		load_out  = 1'b0;
		ctrl.load = acc;
		ctrl.step = 1'b0;
		case (state_q)
			grn_pkg::ST_IDLE: begin
				if (acc) state_n = grn_pkg::ST_DIV;
			end
			grn_pkg::ST_DIV: begin
				ctrl.step = 1'b1;
				if (cnt_q == grn_pkg::DIV_LAST) state_n = grn_pkg::ST_DONE;
			end
			grn_pkg::ST_DONE: begin
				if (!out_valid || !out_stall) begin
					load_out = 1'b1;
					state_n  = grn_pkg::ST_IDLE;
				end
			end
			default: state_n = grn_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= grn_pkg::ST_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
			prev_q    <= '0;
			first_q   <= 1'b1;
			for (int i = 0; i < grn_pkg::STICKS; i++) begin
				lo_q[i] <= grn_pkg::STICK_LOW_SEED;
				hi_q[i] <= grn_pkg::STICK_HIGH_SEED;
			end
			for (int t = 0; t < 2; t++) begin
				tlo_q[t] <= grn_pkg::TRIG_LOW_SEED;
				thi_q[t] <= grn_pkg::TRIG_HIGH_SEED;
			end
		end else begin
			state_q <= state_n;
			cnt_q   <= (state_q == grn_pkg::ST_DIV) ? cnt_q + 1'b1 : '0;
			if (load_out) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (acc) begin
				prev_q  <= keys;
				first_q <= 1'b0;
				for (int i = 0; i < grn_pkg::STICKS; i++) begin
					if (raw[i] < lo_q[i]) lo_q[i] <= raw[i];
					if (raw[i] > hi_q[i]) hi_q[i] <= raw[i];
				end
				for (int t = 0; t < 2; t++) begin
					if (traw[t] < tlo_q[t]) tlo_q[t] <= traw[t];
					if (traw[t] > thi_q[t]) thi_q[t] <= traw[t];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			keys_q <= keys;
			chg_q  <= first_q ? 16'hffff : (keys ^ prev_q);
			neg_q  <= neg;
		end
		if (load_out) begin
			key_state      <= keys_q;
			key_changed    <= chg_q;
			left_x_scaled  <= stick[0];
			left_y_scaled  <= stick[1];
			right_x_scaled <= stick[2];
			right_y_scaled <= stick[3];
			brake_level    <= trig[0];
			gas_level      <= trig[1];
		end
	end

	for (genvar g = 0; g < grn_pkg::LANES; g++) begin : g_lane
		grn_div_lane u_lane (
			.clk  (clk),
			.ctrl (ctrl),
			.num  (num[g]),
			.den  (den[g]),
			.quo  (quo[g])
		);
	end

	grn_merge u_merge (
		.quo   (quo),
		.neg   (neg_q),
		.stick (stick),
		.trig  (trig)
	);

endmodule

// ----- src/grn_div_lane.sv -----
// one lane: restoring divider, one quotient bit per cycle
module grn_div_lane (
	input  logic                          clk,
	input  grn_pkg::lane_ctrl_t           ctrl,
	input  logic [grn_pkg::NUM_W-1:0]     num,
	input  logic [grn_pkg::DEN_W-1:0]     den,
	output logic [grn_pkg::NUM_W-1:0]     quo
);

	logic [grn_pkg::NUM_W-1:0] quo_q;
	logic [grn_pkg::DEN_W-1:0] rem_q;
	logic [grn_pkg::DEN_W-1:0] den_q;
	logic [grn_pkg::DEN_W:0]   sh;
	logic                      ge;
	logic [grn_pkg::DEN_W:0]   diff;

	always_comb begin
		sh   = {rem_q, quo_q[grn_pkg::NUM_W-1]};
		ge   = sh >= {1'b0, den_q};
		diff = sh - {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (ctrl.step) begin
			quo_q <= {quo_q[grn_pkg::NUM_W-2:0], ge};
			rem_q <= ge ? diff[grn_pkg::DEN_W-1:0] : sh[grn_pkg::DEN_W-1:0];
		end
	end

	assign quo = quo_q;

endmodule

// ----- src/grn_merge.sv -----
// merge of lane quotients: sign, inversion and saturation
module grn_merge (
	input  logic [grn_pkg::NUM_W-1:0] quo [grn_pkg::LANES],
	input  logic [grn_pkg::STICKS-1:0] neg,
	output logic signed [15:0]        stick [grn_pkg::STICKS],
	output logic [9:0]                trig  [2]
);

	logic [grn_pkg::NUM_W-1:0] negq [grn_pkg::STICKS];

	always_comb begin
		for (int i = 0; i < grn_pkg::STICKS; i++) begin
			negq[i] = -quo[i];
			if (neg[i] ^ i[0]) begin
				stick[i] = (quo[i] > grn_pkg::NEG_FULL) ? 16'sh8000 : signed'(negq[i][15:0]);
			end else begin
				stick[i] = (quo[i] > grn_pkg::POS_FULL) ? 16'sh7fff : signed'(quo[i][15:0]);
			end
		end
		for (int t = 0; t < 2; t++) begin
			trig[t] = (quo[grn_pkg::STICKS+t] > grn_pkg::TRIG_FULL) ? 10'h3ff :
				quo[grn_pkg::STICKS+t][9:0];
		end
	end

endmodule

// ----- src/grn_checker.sv -----
// port level checks for the pad report normalizer, bound to the top level
module grn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] key_state,
	input logic [15:0] key_changed
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(key_state) && $stable(key_changed))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("request taken while lanes busy");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid)) else $error("result before divide");

endmodule

bind gamepad_report_autorange_normalizer grn_checker u_grn_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.key_state   (key_state),
	.key_changed (key_changed)
);
